[design/dop_pkg.sv]
// shared types, constants and helpers for the disc overlap push-out block
package dop_pkg;

  localparam int CW        = 31;            // coordinate width, signed Q15.16
  localparam int RW        = 30;            // radius width, unsigned Q14.16
  localparam int SQ_STEPS  = 32;            // root bits
  localparam int DIV_STEPS = 31;            // quotient bits
  localparam int REM_W     = 34;            // root remainder width
  localparam int DREM_W    = 34;            // divider remainder width

  localparam logic [1:0] OP_BOTH  = 2'd0;
  localparam logic [1:0] OP_DISC  = 2'd1;
  localparam logic [1:0] OP_POINT = 2'd2;

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic [1:0]           op;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic                 neg_x;
    logic                 neg_y;
    logic [CW-1:0]        mag_x;
    logic [CW-1:0]        mag_y;
    logic [CW-1:0]        rsum;
    logic                 ok;
  } side_t;

  // clamp a widened sum to the coordinate range
  function automatic logic signed [CW-1:0] sat(input logic signed [CW+1:0] v);
    logic signed [CW+1:0] hi;
    logic signed [CW+1:0] lo;
    hi = {{2{COORD_MAX[CW-1]}}, COORD_MAX};
    lo = {{2{COORD_MIN[CW-1]}}, COORD_MIN};
    if (v > hi) begin
      sat = COORD_MAX;
    end else if (v < lo) begin
      sat = COORD_MIN;
    end else begin
      sat = v[CW-1:0];
    end
  endfunction

endpackage

[design/dop_in_if.sv]
// input and result channel interfaces of the disc overlap push-out block
interface dop_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            opcode;
  logic signed [dop_pkg::CW-1:0]         first_x;
  logic signed [dop_pkg::CW-1:0]         first_y;
  logic [dop_pkg::RW-1:0]                first_radius;
  logic signed [dop_pkg::CW-1:0]         second_x;
  logic signed [dop_pkg::CW-1:0]         second_y;
  logic [dop_pkg::RW-1:0]                second_radius;
  modport source(output valid, opcode, first_x, first_y, first_radius,
                 second_x, second_y, second_radius, input ready);
  modport sink(input valid, opcode, first_x, first_y, first_radius,
               second_x, second_y, second_radius, output ready);
endinterface

interface dop_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dop_pkg::CW-1:0]         first_new_x;
  logic signed [dop_pkg::CW-1:0]         first_new_y;
  logic signed [dop_pkg::CW-1:0]         second_new_x;
  logic signed [dop_pkg::CW-1:0]         second_new_y;
  logic                                  pushed;
  modport source(output valid, first_new_x, first_new_y, second_new_x,
                 second_new_y, pushed, input ready);
  modport sink(input valid, first_new_x, first_new_y, second_new_x,
               second_new_y, pushed, output ready);
endinterface

[design/disc_overlap_push_out.sv]
// top level: pipelined disc overlap resolution
// One pair enters per cycle while the pipe advances, and its result passes through
// 69 register stages: the 32-stage square root (one root bit per stage), the 31-stage
// restoring divider (one quotient bit per stage), and the front, square, sum,
// overlap, multiply and output stages. The whole pipe advances together: it
// moves whenever the output register is empty or being taken, so bubbles are
// squeezed out only at the output and a stall freezes every stage in place.
module disc_overlap_push_out (
  input  logic      clk,
  input  logic      rst_n,
  dop_in_if.sink    in_item,
  dop_out_if.source out_item
);

  localparam int CW  = dop_pkg::CW;
  localparam int NSQ = dop_pkg::SQ_STEPS;
  localparam int NDV = dop_pkg::DIV_STEPS;
  localparam int RMW = dop_pkg::REM_W;
  localparam int DRW = dop_pkg::DREM_W;

  // global advance: the pipe moves when the output slot frees up
  logic adv;
  assign adv          = !out_item.valid || out_item.ready;
  assign in_item.ready = adv;

  // front stage: deltas, magnitudes, radius sum
  logic signed [CW:0] ax_e, ay_e, bx_e, by_e, dx, dy;
  logic [CW:0]        ux, uy;
  dop_pkg::side_t     fr_nxt;

  always_comb begin
    ax_e = {in_item.first_x[CW-1], in_item.first_x};
    ay_e = {in_item.first_y[CW-1], in_item.first_y};
    bx_e = {in_item.second_x[CW-1], in_item.second_x};
    by_e = {in_item.second_y[CW-1], in_item.second_y};
    if (in_item.opcode == dop_pkg::OP_BOTH) begin
      dx = bx_e - ax_e;
      dy = by_e - ay_e;
    end else begin
      dx = ax_e - bx_e;
      dy = ay_e - by_e;
    end
    ux = dx[CW] ? -dx : dx;
    uy = dy[CW] ? -dy : dy;
    fr_nxt.op    = in_item.opcode;
    fr_nxt.ax    = in_item.first_x;
    fr_nxt.ay    = in_item.first_y;
    fr_nxt.bx    = in_item.second_x;
    fr_nxt.by    = in_item.second_y;
    fr_nxt.neg_x = dx[CW];
    fr_nxt.neg_y = dy[CW];
    fr_nxt.mag_x = ux[CW-1:0];
    fr_nxt.mag_y = uy[CW-1:0];
    fr_nxt.rsum  = {1'b0, in_item.first_radius}
                 + ((in_item.opcode == dop_pkg::OP_POINT) ? '0
                    : {1'b0, in_item.second_radius});
    fr_nxt.ok    = 1'b0;
  end

  dop_pkg::side_t fr_r, sq1_r;
  logic           fr_v_r, sq1_v_r;
  logic [2*CW-1:0] sqx_r, sqy_r;

  // square root pipe: index 0 is the radicand register
  dop_pkg::side_t     rt_side_r [NSQ+1];
  logic [2*NSQ-1:0]   rt_rad_r  [NSQ+1];
  logic [RMW-1:0]     rt_rem_r  [NSQ+1];
  logic [NSQ-1:0]     rt_root_r [NSQ+1];
  logic [NSQ:0]       rt_v_r;

  dop_pkg::side_t     rt_side_nxt [NSQ];
  logic [2*NSQ-1:0]   rt_rad_nxt  [NSQ];
  logic [RMW-1:0]     rt_rem_nxt  [NSQ];
  logic [NSQ-1:0]     rt_root_nxt [NSQ];

  always_comb begin
    for (int k = 0; k < NSQ; k++) begin
      logic [RMW+1:0] t;
      logic [RMW+1:0] trial;
      t     = {rt_rem_r[k], rt_rad_r[k][2*NSQ-1 -: 2]};
      trial = {{(RMW+1-NSQ-1){1'b0}}, rt_root_r[k], 2'b01};
      rt_side_nxt[k] = rt_side_r[k];
      rt_rad_nxt[k]  = {rt_rad_r[k][2*NSQ-3:0], 2'b00};
      if (t >= trial) begin
        rt_rem_nxt[k]  = RMW'(t - trial);
        rt_root_nxt[k] = {rt_root_r[k][NSQ-2:0], 1'b1};
      end else begin
        rt_rem_nxt[k]  = t[RMW-1:0];
        rt_root_nxt[k] = {rt_root_r[k][NSQ-2:0], 1'b0};
      end
    end
  end

  // overlap stage
  logic [NSQ-1:0]  cdist;
  logic            ok;
  dop_pkg::side_t  ov_nxt;
  logic [CW-1:0]   ovl_nxt;
  logic [NSQ:0]    div_nxt;

  always_comb begin
    cdist  = rt_root_r[NSQ];
    ok     = (rt_side_r[NSQ].op inside {dop_pkg::OP_BOTH, dop_pkg::OP_DISC,
                                        dop_pkg::OP_POINT})
             && (cdist != '0) && ({1'b0, rt_side_r[NSQ].rsum} >= cdist);
    ov_nxt    = rt_side_r[NSQ];
    ov_nxt.ok = ok;
    if (ok) begin
      ovl_nxt = CW'({1'b0, rt_side_r[NSQ].rsum} - cdist);
      div_nxt = (rt_side_r[NSQ].op == dop_pkg::OP_BOTH) ? {cdist, 1'b0} : {1'b0, cdist};
    end else begin
      ovl_nxt = '0;
      div_nxt = (NSQ+1)'(1);
    end
  end

  dop_pkg::side_t ov_r;
  logic           ov_v_r;
  logic [CW-1:0]  ovl_r;
  logic [NSQ:0]   ovd_r;

  // divider pipe: index 0 is the product register
  dop_pkg::side_t   dv_side_r [NDV+1];
  logic [NSQ:0]     dv_d_r    [NDV+1];
  logic [DRW-1:0]   dv_rx_r   [NDV+1];
  logic [DRW-1:0]   dv_ry_r   [NDV+1];
  logic [NDV-1:0]   dv_lx_r   [NDV+1];
  logic [NDV-1:0]   dv_ly_r   [NDV+1];
  logic [NDV-1:0]   dv_qx_r   [NDV+1];
  logic [NDV-1:0]   dv_qy_r   [NDV+1];
  logic [NDV:0]     dv_v_r;

  logic [DRW-1:0]   dv_rx_nxt [NDV];
  logic [DRW-1:0]   dv_ry_nxt [NDV];
  logic [NDV-1:0]   dv_qx_nxt [NDV];
  logic [NDV-1:0]   dv_qy_nxt [NDV];

  always_comb begin
    for (int k = 0; k < NDV; k++) begin
      logic [DRW:0] tx;
      logic [DRW:0] ty;
      logic [DRW:0] dd;
      tx = {dv_rx_r[k], dv_lx_r[k][NDV-1]};
      ty = {dv_ry_r[k], dv_ly_r[k][NDV-1]};
      dd = (DRW+1)'(dv_d_r[k]);
      if (tx >= dd) begin
        dv_rx_nxt[k] = DRW'(tx - dd);
        dv_qx_nxt[k] = {dv_qx_r[k][NDV-2:0], 1'b1};
      end else begin
        dv_rx_nxt[k] = tx[DRW-1:0];
        dv_qx_nxt[k] = {dv_qx_r[k][NDV-2:0], 1'b0};
      end
      if (ty >= dd) begin
        dv_ry_nxt[k] = DRW'(ty - dd);
        dv_qy_nxt[k] = {dv_qy_r[k][NDV-2:0], 1'b1};
      end else begin
        dv_ry_nxt[k] = ty[DRW-1:0];
        dv_qy_nxt[k] = {dv_qy_r[k][NDV-2:0], 1'b0};
      end
    end
  end

  logic [2*CW-1:0] px, py;
  assign px = ov_r.mag_x * ovl_r;
  assign py = ov_r.mag_y * ovl_r;

  // output stage: signed offsets, apply, saturate
  dop_pkg::side_t         fin;
  logic signed [CW+1:0]   ox, oy;
  logic signed [CW-1:0]   nax_nxt, nay_nxt, nbx_nxt, nby_nxt;

  always_comb begin
    fin = dv_side_r[NDV];
    ox  = fin.neg_x ? -$signed({2'b00, dv_qx_r[NDV]}) : $signed({2'b00, dv_qx_r[NDV]});
    oy  = fin.neg_y ? -$signed({2'b00, dv_qy_r[NDV]}) : $signed({2'b00, dv_qy_r[NDV]});
    nax_nxt = fin.ax;
    nay_nxt = fin.ay;
    nbx_nxt = fin.bx;
    nby_nxt = fin.by;
    if (fin.ok) begin
      if (fin.op == dop_pkg::OP_BOTH) begin
        nax_nxt = dop_pkg::sat($signed({{2{fin.ax[CW-1]}}, fin.ax}) - ox);
        nay_nxt = dop_pkg::sat($signed({{2{fin.ay[CW-1]}}, fin.ay}) - oy);
        nbx_nxt = dop_pkg::sat($signed({{2{fin.bx[CW-1]}}, fin.bx}) + ox);
        nby_nxt = dop_pkg::sat($signed({{2{fin.by[CW-1]}}, fin.by}) + oy);
      end else begin
        nax_nxt = dop_pkg::sat($signed({{2{fin.ax[CW-1]}}, fin.ax}) + ox);
        nay_nxt = dop_pkg::sat($signed({{2{fin.ay[CW-1]}}, fin.ay}) + oy);
      end
    end
  end

  logic                 o_v_r;
  logic [1:0]           o_op_r;
  logic signed [CW-1:0] o_bx_in_r, o_by_in_r;

  // control: valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r  <= 1'b0;
      sq1_v_r <= 1'b0;
      rt_v_r  <= '0;
      ov_v_r  <= 1'b0;
      dv_v_r  <= '0;
      o_v_r   <= 1'b0;
    end else if (adv) begin
      fr_v_r    <= in_item.valid;
      sq1_v_r   <= fr_v_r;
      rt_v_r    <= {rt_v_r[NSQ-1:0], sq1_v_r};
      ov_v_r    <= rt_v_r[NSQ];
      dv_v_r    <= {dv_v_r[NDV-1:0], ov_v_r};
      o_v_r     <= dv_v_r[NDV];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      fr_r  <= fr_nxt;
      sq1_r <= fr_r;
      sqx_r <= fr_r.mag_x * fr_r.mag_x;
      sqy_r <= fr_r.mag_y * fr_r.mag_y;
      rt_side_r[0] <= sq1_r;
      rt_rad_r[0]  <= (2*NSQ)'(sqx_r) + (2*NSQ)'(sqy_r);
      rt_rem_r[0]  <= '0;
      rt_root_r[0] <= '0;
      for (int k = 0; k < NSQ; k++) begin
        rt_side_r[k+1] <= rt_side_nxt[k];
        rt_rad_r[k+1]  <= rt_rad_nxt[k];
        rt_rem_r[k+1]  <= rt_rem_nxt[k];
        rt_root_r[k+1] <= rt_root_nxt[k];
      end
      ov_r  <= ov_nxt;
      ovl_r <= ovl_nxt;
      ovd_r <= div_nxt;
      dv_side_r[0] <= ov_r;
      dv_d_r[0]    <= ovd_r;
      dv_rx_r[0]   <= DRW'(px[2*CW-1:NDV]);
      dv_ry_r[0]   <= DRW'(py[2*CW-1:NDV]);
      dv_lx_r[0]   <= px[NDV-1:0];
      dv_ly_r[0]   <= py[NDV-1:0];
      dv_qx_r[0]   <= '0;
      dv_qy_r[0]   <= '0;
      for (int k = 0; k < NDV; k++) begin
        dv_side_r[k+1] <= dv_side_r[k];
        dv_d_r[k+1]    <= dv_d_r[k];
        dv_rx_r[k+1]   <= dv_rx_nxt[k];
        dv_ry_r[k+1]   <= dv_ry_nxt[k];
        dv_lx_r[k+1]   <= {dv_lx_r[k][NDV-2:0], 1'b0};
        dv_ly_r[k+1]   <= {dv_ly_r[k][NDV-2:0], 1'b0};
        dv_qx_r[k+1]   <= dv_qx_nxt[k];
        dv_qy_r[k+1]   <= dv_qy_nxt[k];
      end
      out_item.first_new_x  <= nax_nxt;
      out_item.first_new_y  <= nay_nxt;
      out_item.second_new_x <= nbx_nxt;
      out_item.second_new_y <= nby_nxt;
      out_item.pushed       <= fin.ok;
      o_op_r                <= fin.op;
      o_bx_in_r             <= fin.bx;
      o_by_in_r             <= fin.by;
    end
  end

  assign out_item.valid = o_v_r;

  // a held result freezes the whole pipe
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && !out_item.ready) |=> ($stable(rt_v_r) && $stable(dv_v_r)))
    else $error("pipe moved during stall");

  // only mode 0 moves the second disc
  a_second_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && o_op_r != dop_pkg::OP_BOTH) |->
      (out_item.second_new_x == o_bx_in_r && out_item.second_new_y == o_by_in_r))
    else $error("second disc moved outside mode 0");

  // an unused opcode never reports a push
  a_bad_op: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && o_op_r != dop_pkg::OP_BOTH && o_op_r != dop_pkg::OP_DISC
     && o_op_r != dop_pkg::OP_POINT) |-> !out_item.pushed)
    else $error("push reported for unused opcode");

  // reset empties the output slot
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_item.valid)
    else $error("result valid after reset");

endmodule

[tb/dop_tb_if.sv]
// note: the block's interfaces live in design/dop_in_if.sv; this file holds nothing else
`timescale 1ns / 1ps

[tb/disc_overlap_push_out_checker.sv]
// checker: predicts the result of each pair and compares the results in order
`timescale 1ns / 1ps
module disc_overlap_push_out_checker (
  input  logic clk,
  input  logic rst_n,
  dop_in_if  in_mon,
  dop_out_if out_mon,
  output int errors
);
  localparam int CW = dop_pkg::CW;

  typedef struct packed {
    logic signed [CW-1:0] fx;
    logic signed [CW-1:0] fy;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic                 pushed;
  } push_res_t;

  push_res_t pending_q[$];

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > longint'(dop_pkg::COORD_MAX)) return longint'(dop_pkg::COORD_MAX);
    if (v < longint'(dop_pkg::COORD_MIN)) return longint'(dop_pkg::COORD_MIN);
    return v;
  endfunction

  // truncated toward zero
  function automatic longint share(longint d, longint unsigned ov, longint unsigned dv);
    longint unsigned m;
    longint unsigned q;
    m = (d < 0) ? longint'(-d) : d;
    q = (m * ov) / dv;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic push_res_t resolve_pair(logic [1:0] op, longint ax, longint ay,
                                             longint unsigned ar, longint bx, longint by,
                                             longint unsigned br);
    push_res_t r;
    longint dx, dy, ox, oy;
    longint unsigned cdist, rs, ov;
    r.fx = CW'(ax); r.fy = CW'(ay); r.sx = CW'(bx); r.sy = CW'(by); r.pushed = 1'b0;
    if (op inside {dop_pkg::OP_BOTH, dop_pkg::OP_DISC, dop_pkg::OP_POINT}) begin
      if (op == dop_pkg::OP_POINT) br = 0;
      if (op == dop_pkg::OP_BOTH) begin
        dx = bx - ax; dy = by - ay;
      end else begin
        dx = ax - bx; dy = ay - by;
      end
      cdist = root_floor(longint'(dx < 0 ? -dx : dx) * longint'(dx < 0 ? -dx : dx)
                         + longint'(dy < 0 ? -dy : dy) * longint'(dy < 0 ? -dy : dy));
      rs = ar + br;
      if (cdist != 0 && rs >= cdist) begin
        ov = rs - cdist;
        r.pushed = 1'b1;
        if (op == dop_pkg::OP_BOTH) begin
          ox = share(dx, ov, cdist * 2);
          oy = share(dy, ov, cdist * 2);
          r.fx = CW'(clamp_coord(ax - ox));
          r.fy = CW'(clamp_coord(ay - oy));
          r.sx = CW'(clamp_coord(bx + ox));
          r.sy = CW'(clamp_coord(by + oy));
        end else begin
          ox = share(dx, ov, cdist);
          oy = share(dy, ov, cdist);
          r.fx = CW'(clamp_coord(ax + ox));
          r.fy = CW'(clamp_coord(ay + oy));
        end
      end
    end
    return r;
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    push_res_t want;
    push_res_t got;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        pending_q.push_back(resolve_pair(in_mon.opcode, in_mon.first_x, in_mon.first_y,
                                         in_mon.first_radius, in_mon.second_x,
                                         in_mon.second_y, in_mon.second_radius));
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.first_new_x, out_mon.first_new_y, out_mon.second_new_x,
                out_mon.second_new_y, out_mon.pushed};
        if (pending_q.size() == 0) begin
          $display("%0t unexpected result %h", $time, got);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (want !== got) begin
            $display("%0t mismatch exp fx=%0d fy=%0d sx=%0d sy=%0d p=%0b", $time,
                     want.fx, want.fy, want.sx, want.sy, want.pushed);
            $display("%0t          got fx=%0d fy=%0d sx=%0d sy=%0d p=%0b", $time,
                     got.fx, got.fy, got.sx, got.sy, got.pushed);
            errors++;
          end
        end
      end
    end
  end

  function automatic int waiting();
    return pending_q.size();
  endfunction
endmodule

[tb/disc_overlap_push_out_test.sv]
// testbench top: drives disc pairs with random gaps and stalls, gives the verdict
`timescale 1ns / 1ps
module disc_overlap_push_out_test;
  localparam int CW = dop_pkg::CW;
  localparam int RW = dop_pkg::RW;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int LATENCY = 68;
  localparam int N_RANDOM = 1030;
  localparam longint CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending = 0;
  longint cycles;

  dop_in_if  in_ch();
  dop_out_if out_ch();

  disc_overlap_push_out dut (.clk(clk), .rst_n(rst_n), .in_item(in_ch), .out_item(out_ch));

  disc_overlap_push_out_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch),
                                     .out_mon(out_ch), .errors(errors));

  // in-flight count kept here so the top can wait for the pipe to drain
  always @(posedge clk)
    if (rst_n)
      pending <= pending + (in_ch.valid && in_ch.ready) - (out_ch.valid && out_ch.ready);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // global watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("** disc_overlap_push_out: FAILED **");
        $finish;
      end
    end
  end

  // receiver stalls drawn per transfer, with quiet stretches
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      if (cycles % 4000 < 600) hold = 0;
      repeat (hold) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk iff out_ch.valid);
    end
  end

  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return dop_pkg::COORD_MAX;
      1: return dop_pkg::COORD_MIN;
      2: return CW'($urandom_range(0, 2000) - 1000);
      default: return CW'($urandom);
    endcase
  endfunction

  // send one pair; a random gap before it, none in quiet stretches
  task automatic send_pair(logic [1:0] op, logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                           logic [RW-1:0] ar, logic signed [CW-1:0] bx,
                           logic signed [CW-1:0] by, logic [RW-1:0] br);
    int gap;
    gap = (cycles % 3000 < 500) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.first_x       <= ax;
    in_ch.first_y       <= ay;
    in_ch.first_radius  <= ar;
    in_ch.second_x      <= bx;
    in_ch.second_y      <= by;
    in_ch.second_radius <= br;
    @(posedge clk iff in_ch.ready);
  endtask

  // near pair: second center close to the first, radii drawn from the same span, so the discs often overlap
  task automatic send_touching(logic [1:0] op);
    logic signed [CW-1:0] ax, ay;
    int span;
    span = 1 << $urandom_range(4, 26);
    ax = pick_coord();
    ay = pick_coord();
    send_pair(op, ax, ay, RW'($urandom_range(0, span)),
              CW'(ax + $urandom_range(0, span) - span / 2),
              CW'(ay + $urandom_range(0, span) - span / 2),
              RW'($urandom_range(0, span)));
  endtask

  initial begin
    logic [1:0] op;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = dop_pkg::OP_BOTH;
    in_ch.first_x = '0;
    in_ch.first_y = '0;
    in_ch.first_radius = '0;
    in_ch.second_x = '0;
    in_ch.second_y = '0;
    in_ch.second_radius = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every mode, coincident centers, zero and negative overlap,
    // saturation at both ends, full radii, unused opcode
    send_pair(dop_pkg::OP_BOTH, 0, 0, 30'h10000, 31'h10000, 0, 30'h10000);
    send_pair(dop_pkg::OP_DISC, 0, 0, 30'h10000, 31'h8000, 31'h8000, 30'h10000);
    send_pair(dop_pkg::OP_POINT, 31'h100, -31'sh200, 30'h10000, 0, 0, 30'h3FFFFFFF);
    send_pair(dop_pkg::OP_BOTH, 5, 5, 30'h3FFFFFFF, 5, 5, 30'h3FFFFFFF);
    send_pair(dop_pkg::OP_DISC, 0, 0, 30'h8000, 31'h10000, 0, 30'h8000);
    send_pair(dop_pkg::OP_POINT, 0, 31'h10000, 30'h10000, 0, 0, 0);
    send_pair(dop_pkg::OP_BOTH, 0, 0, 1, 31'h20000, 0, 1);
    send_pair(dop_pkg::OP_BOTH, dop_pkg::COORD_MAX, dop_pkg::COORD_MAX, 30'h3FFFFFFF,
              dop_pkg::COORD_MAX - 31'sd1, dop_pkg::COORD_MAX - 31'sd1, 30'h3FFFFFFF);
    send_pair(dop_pkg::OP_DISC, dop_pkg::COORD_MIN, dop_pkg::COORD_MIN, 30'h3FFFFFFF,
              dop_pkg::COORD_MIN + 31'sd1, dop_pkg::COORD_MIN + 31'sd1, 30'h3FFFFFFF);
    send_pair(dop_pkg::OP_BOTH, dop_pkg::COORD_MIN, dop_pkg::COORD_MAX, 30'h3FFFFFFF,
              dop_pkg::COORD_MAX, dop_pkg::COORD_MIN, 30'h3FFFFFFF);
    send_pair(dop_pkg::OP_POINT, dop_pkg::COORD_MAX, dop_pkg::COORD_MIN, 30'h3FFFFFFF,
              dop_pkg::COORD_MIN, dop_pkg::COORD_MAX, 0);
    send_pair(OP_UNUSED, 7, 8, 30'h3FFFFFFF, 9, 10, 30'h3FFFFFFF);
    send_pair(dop_pkg::OP_DISC, -31'sh10000, 0, 30'h20000, 0, 0, 30'h20000);
    send_pair(dop_pkg::OP_BOTH, 0, -31'sh30000, 30'h10000, 0, 31'h30000, 30'h2AAAA);
    send_pair(dop_pkg::OP_POINT, -3, -4, 30'h2, 0, 0, 30'h3FFFFFFF);

    // hold off until everything in flight has come back
    in_ch.valid <= 1'b0;
    @(posedge clk iff pending == 0);

    for (int i = 0; i < N_RANDOM; i++) begin
      op = ($urandom_range(0, 19) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 3) != 0)
        send_touching(op);
      else
        send_pair(op, pick_coord(), pick_coord(), RW'($urandom), pick_coord(), pick_coord(),
                  RW'($urandom));
    end
    in_ch.valid <= 1'b0;

    @(posedge clk iff pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("** disc_overlap_push_out: PASSED **");
    else
      $display("** disc_overlap_push_out: FAILED **");
    $finish;
  end
endmodule
